// ===== rtl/awcd_pkg.sv =====
// ----------------------------------------------------------------------------
// Arc wall contact detect package
// Shared widths, the sideband record carried down the pipeline, register
// indexes and rounding/saturation helpers.
// ----------------------------------------------------------------------------
package awcd_pkg;

  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 19;
  localparam int REM_W      = 52;
  localparam int GAP_W      = 43;

  localparam logic [2:0] REG_AXIS_VECTOR  = 3'd0;
  localparam logic [2:0] REG_AXIS_POINT_X = 3'd1;
  localparam logic [2:0] REG_AXIS_POINT_Y = 3'd2;
  localparam logic [2:0] REG_AXIS_POINT_Z = 3'd3;
  localparam logic [2:0] REG_WALL_RADIUS  = 3'd4;
  localparam logic [2:0] REG_CENTRE_DIR   = 3'd5;
  localparam logic [2:0] REG_COS_HALF     = 3'd6;
  localparam logic [2:0] REG_FULL_CIRCLE  = 3'd7;

  typedef struct packed {
    logic signed [31:0]       px;
    logic signed [31:0]       py;
    logic signed [31:0]       pz;
    logic [30:0]              prad;
    logic [30:0]              reach;
    logic [2:0]               neg;
    logic [2:0][30:0]         c;
    logic signed [6:0]        sh;
    logic                     zero;
    logic signed [GAP_W-1:0]  gap;
    logic                     miss;
  } awcd_side_t;

  // round to nearest, ties away from zero, scale by 2^-sh
  function automatic logic signed [63:0] rnd_half(input logic signed [63:0] v,
                                                  input int unsigned sh);
    logic [63:0] mag;
    logic [63:0] q;
    mag = v[63] ? 64'(-v) : 64'(v);
    q   = (mag + (64'd1 << (sh - 1))) >> sh;
    return v[63] ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return 32'(v);
    end
  endfunction

endpackage

// ===== rtl/awcd_sqrt.sv =====
// ----------------------------------------------------------------------------
// Pipelined integer square root
// One result bit per stage, floor root of a 64-bit value, sideband carried.
// ----------------------------------------------------------------------------
module awcd_sqrt (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  vld_in,
  input  logic [63:0]           rad_in,
  input  awcd_pkg::awcd_side_t  side_in,
  output logic                  vld_out,
  output logic [31:0]           root_out,
  output awcd_pkg::awcd_side_t  side_out
);
  import awcd_pkg::*;

  logic [63:0] rem_r  [SQRT_STEPS];
  logic [63:0] res_r  [SQRT_STEPS];
  logic        vld_r  [SQRT_STEPS];
  awcd_side_t  side_r [SQRT_STEPS];

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_step
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
    logic [63:0] rem_i;
    logic [63:0] res_i;
    logic [63:0] trial;
    logic [63:0] rem_nxt;
    logic [63:0] res_nxt;
    logic        vld_i;
    awcd_side_t  side_i;

    if (j == 0) begin : g_first
      assign rem_i  = rad_in;
      assign res_i  = '0;
      assign vld_i  = vld_in;
      assign side_i = side_in;
    end else begin : g_next
      assign rem_i  = rem_r[j-1];
      assign res_i  = res_r[j-1];
      assign vld_i  = vld_r[j-1];
      assign side_i = side_r[j-1];
    end

    always_comb begin
      trial = res_i + BIT;
      if (rem_i >= trial) begin
        rem_nxt = rem_i - trial;
        res_nxt = (res_i >> 1) + BIT;
      end else begin
        rem_nxt = rem_i;
        res_nxt = res_i >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (en) begin
        vld_r[j] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j]  <= rem_nxt;
        res_r[j]  <= res_nxt;
        side_r[j] <= side_i;
      end
    end
  end

  assign vld_out  = vld_r[SQRT_STEPS-1];
  assign root_out = 32'(res_r[SQRT_STEPS-1]);
  assign side_out = side_r[SQRT_STEPS-1];

endmodule

// ===== rtl/awcd_div.sv =====
// ----------------------------------------------------------------------------
// Pipelined normal divider
// Three lanes of restoring division, q = (c*2^19 + L) / (2L), one bit a stage.
// ----------------------------------------------------------------------------
module awcd_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  vld_in,
  input  logic [31:0]           root_in,
  input  awcd_pkg::awcd_side_t  side_in,
  output logic                  vld_out,
  output logic [2:0][18:0]      q_out,
  output awcd_pkg::awcd_side_t  side_out
);
  import awcd_pkg::*;

  logic [2:0][REM_W-1:0] rem_r  [DIV_STEPS];
  logic [2:0][18:0]      q_r    [DIV_STEPS];
  logic [31:0]           den_r  [DIV_STEPS];
  logic                  vld_r  [DIV_STEPS];
  awcd_side_t            side_r [DIV_STEPS];

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
    logic [2:0][REM_W-1:0] rem_i;
    logic [2:0][18:0]      q_i;
    logic [31:0]           den_i;
    logic                  vld_i;
    awcd_side_t            side_i;
    logic [REM_W-1:0]      dsh;
    logic [2:0][REM_W-1:0] rem_nxt;
    logic [2:0][18:0]      q_nxt;

    if (j == 0) begin : g_first
      always_comb begin
        for (int i = 0; i < 3; i++) begin
          rem_i[i] = (REM_W'(side_in.c[i]) << 19) + REM_W'(root_in);
        end
      end
      assign q_i    = '0;
      assign den_i  = root_in;
      assign vld_i  = vld_in;
      assign side_i = side_in;
    end else begin : g_next
      assign rem_i  = rem_r[j-1];
      assign q_i    = q_r[j-1];
      assign den_i  = den_r[j-1];
      assign vld_i  = vld_r[j-1];
      assign side_i = side_r[j-1];
    end

    always_comb begin
      dsh = REM_W'({den_i, 1'b0}) << (DIV_STEPS - 1 - j);
      for (int i = 0; i < 3; i++) begin
        q_nxt[i] = q_i[i];
        if (rem_i[i] >= dsh) begin
          rem_nxt[i] = rem_i[i] - dsh;
          q_nxt[i][DIV_STEPS-1-j] = 1'b1;
        end else begin
          rem_nxt[i] = rem_i[i];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (en) begin
        vld_r[j] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j]  <= rem_nxt;
        q_r[j]    <= q_nxt;
        den_r[j]  <= den_i;
        side_r[j] <= side_i;
      end
    end
  end

  assign vld_out  = vld_r[DIV_STEPS-1];
  assign q_out    = q_r[DIV_STEPS-1];
  assign side_out = side_r[DIV_STEPS-1];

endmodule

// ===== rtl/arc_wall_contact_detect.sv =====
// ----------------------------------------------------------------------------
// Arc wall contact detect
// Tests one particle per transaction against a cylindrical arc wall and gives
// gap, inward normal, overlap and contact point.
// ----------------------------------------------------------------------------
//  channel  direction  transaction
//  in_      slave      particle x/y/z, radius, reach radius
//  out_     master     contact flag (tuser), gap, normal, overlap, point
//  cfg_     APB        eight wall registers at byte address 8*i
//
//  One transaction per cycle unless out_ stalls; 9 front stages, 32 root
//  stages, gap stage, 19 divider stages, 2 dot/scale stages, output register.
//  rst_n is synchronous and clears valids and the registers to their defaults.
//  A stall on out_ freezes the whole pipeline; in_tready follows it directly.
// ----------------------------------------------------------------------------
module arc_wall_contact_detect (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [159:0] in_tdata,   // particle_x, particle_y, particle_z, particle_radius,
                                   // reach_radius, zero pad
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [223:0] out_tdata,  // gap, normal_x, normal_y, normal_z, overlap,
                                   // contact_x, contact_y, contact_z, zero pad
  output logic         out_tuser,  // contact
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [5:0]   cfg_paddr,
  input  logic [63:0]  cfg_pwdata,
  output logic [63:0]  cfg_prdata,
  output logic         cfg_pready
);
  import awcd_pkg::*;

  logic [59:0]        axis_r;
  logic signed [31:0] apx_r;
  logic signed [31:0] apy_r;
  logic signed [31:0] apz_r;
  logic [30:0]        wall_r;
  logic [59:0]        cdir_r;
  logic signed [19:0] chs_r;
  logic               full_r;
  logic               cfg_wr;
  logic [2:0]         cfg_idx;
  logic               en;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx    = cfg_paddr[5:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_r <= 60'd288230376151711744;
      apx_r  <= 32'sd0;
      apy_r  <= 32'sd65536;
      apz_r  <= 32'sd0;
      wall_r <= 31'd65536;
      cdir_r <= 60'd824633720832;
      chs_r  <= 20'sd246333;
      full_r <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_AXIS_VECTOR:  axis_r <= cfg_pwdata[59:0];
        REG_AXIS_POINT_X: apx_r  <= $signed(cfg_pwdata[31:0]);
        REG_AXIS_POINT_Y: apy_r  <= $signed(cfg_pwdata[31:0]);
        REG_AXIS_POINT_Z: apz_r  <= $signed(cfg_pwdata[31:0]);
        REG_WALL_RADIUS:  wall_r <= cfg_pwdata[30:0];
        REG_CENTRE_DIR:   cdir_r <= cfg_pwdata[59:0];
        REG_COS_HALF:     chs_r  <= $signed(cfg_pwdata[19:0]);
        REG_FULL_CIRCLE:  full_r <= cfg_pwdata[0];
        default:          full_r <= full_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_AXIS_VECTOR:  cfg_prdata = {4'd0, axis_r};
      REG_AXIS_POINT_X: cfg_prdata = {32'd0, apx_r};
      REG_AXIS_POINT_Y: cfg_prdata = {32'd0, apy_r};
      REG_AXIS_POINT_Z: cfg_prdata = {32'd0, apz_r};
      REG_WALL_RADIUS:  cfg_prdata = {33'd0, wall_r};
      REG_CENTRE_DIR:   cfg_prdata = {4'd0, cdir_r};
      REG_COS_HALF:     cfg_prdata = {44'd0, chs_r};
      REG_FULL_CIRCLE:  cfg_prdata = {63'd0, full_r};
      default:          cfg_prdata = '0;
    endcase
  end

  logic signed [19:0] ax [3];
  logic signed [19:0] cd [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ax[i] = $signed(axis_r[20*i +: 20]);
      cd[i] = $signed(cdir_r[20*i +: 20]);
    end
  end

  logic out_tvalid_r;
  assign en        = !out_tvalid_r || out_tready;
  assign in_tready = en;

  // stage 1: offset from axis point
  logic               s1_vld_r;
  awcd_side_t         s1_side_r, s1_side_nxt;
  logic signed [32:0] s1_d_r [3];
  logic signed [32:0] s1_d_nxt [3];
  always_comb begin
    s1_side_nxt       = '0;
    s1_side_nxt.px    = $signed(in_tdata[31:0]);
    s1_side_nxt.py    = $signed(in_tdata[63:32]);
    s1_side_nxt.pz    = $signed(in_tdata[95:64]);
    s1_side_nxt.prad  = in_tdata[126:96];
    s1_side_nxt.reach = in_tdata[157:127];
    s1_d_nxt[0] = 33'(s1_side_nxt.px) - 33'(apx_r);
    s1_d_nxt[1] = 33'(s1_side_nxt.py) - 33'(apy_r);
    s1_d_nxt[2] = 33'(s1_side_nxt.pz) - 33'(apz_r);
  end

  // stage 2: axis products
  logic               s2_vld_r;
  awcd_side_t         s2_side_r;
  logic signed [32:0] s2_d_r [3];
  logic signed [52:0] s2_pr_r [3];

  // stage 3: projection length
  logic               s3_vld_r;
  awcd_side_t         s3_side_r;
  logic signed [32:0] s3_d_r [3];
  logic signed [36:0] s3_t16_r;
  logic signed [54:0] s3_t;
  assign s3_t = 55'(s2_pr_r[0]) + 55'(s2_pr_r[1]) + 55'(s2_pr_r[2]);

  // stage 4: projection back onto axis
  logic               s4_vld_r;
  awcd_side_t         s4_side_r;
  logic signed [32:0] s4_d_r [3];
  logic signed [56:0] s4_pa_r [3];

  // stage 5: radial vector
  logic               s5_vld_r;
  awcd_side_t         s5_side_r, s5_side_nxt;
  logic [38:0]        s5_mag_r [3];
  logic [38:0]        s5_mag_nxt [3];
  logic signed [39:0] s5_rv [3];
  always_comb begin
    s5_side_nxt = s4_side_r;
    for (int i = 0; i < 3; i++) begin
      s5_rv[i] = 40'(64'(s4_d_r[i]) - rnd_half(64'(s4_pa_r[i]), 18));
      s5_side_nxt.neg[i] = s5_rv[i][39];
      s5_mag_nxt[i] = 39'(s5_rv[i][39] ? -s5_rv[i] : s5_rv[i]);
    end
  end

  // stage 6: leading one of the largest component
  logic               s6_vld_r;
  awcd_side_t         s6_side_r, s6_side_nxt;
  logic [38:0]        s6_mag_r [3];
  logic [38:0]        s6_m;
  logic [5:0]         s6_pos;
  always_comb begin
    s6_m = s5_mag_r[0];
    if (s5_mag_r[1] > s6_m) s6_m = s5_mag_r[1];
    if (s5_mag_r[2] > s6_m) s6_m = s5_mag_r[2];
    s6_pos = '0;
    for (int b = 0; b < 39; b++) begin
      if (s6_m[b]) s6_pos = 6'(b);
    end
    s6_side_nxt      = s5_side_r;
    s6_side_nxt.zero = (s6_m == '0);
    s6_side_nxt.sh   = $signed({1'b0, s6_pos}) - 7'sd30;
  end

  // stage 7: scaled components
  logic       s7_vld_r;
  awcd_side_t s7_side_r, s7_side_nxt;
  logic [4:0] s7_kk;
  always_comb begin
    s7_side_nxt = s6_side_r;
    s7_kk = 5'(-s6_side_r.sh);
    for (int i = 0; i < 3; i++) begin
      if (s6_side_r.sh > 7'sd0) begin
        s7_side_nxt.c[i] = 31'(s6_mag_r[i] >> s6_side_r.sh[3:0]);
      end else begin
        s7_side_nxt.c[i] = 31'(s6_mag_r[i] << s7_kk);
      end
    end
  end

  // stage 8: squares
  logic       s8_vld_r;
  awcd_side_t s8_side_r;
  logic [61:0] s8_sq_r [3];

  // stage 9: sum of squares
  logic       s9_vld_r;
  awcd_side_t s9_side_r;
  logic [63:0] s9_sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
      s6_vld_r <= 1'b0;
      s7_vld_r <= 1'b0;
      s8_vld_r <= 1'b0;
      s9_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_tvalid;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
      s5_vld_r <= s4_vld_r;
      s6_vld_r <= s5_vld_r;
      s7_vld_r <= s6_vld_r;
      s8_vld_r <= s7_vld_r;
      s9_vld_r <= s8_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_side_r <= s1_side_nxt;
      s2_side_r <= s1_side_r;
      s3_side_r <= s2_side_r;
      s4_side_r <= s3_side_r;
      s5_side_r <= s5_side_nxt;
      s6_side_r <= s6_side_nxt;
      s7_side_r <= s7_side_nxt;
      s8_side_r <= s7_side_r;
      s9_side_r <= s8_side_r;
      s3_t16_r  <= 37'(rnd_half(64'(s3_t), 18));
      s6_mag_r  <= s5_mag_r;
      s9_sum_r  <= 64'(s8_sq_r[0]) + 64'(s8_sq_r[1]) + 64'(s8_sq_r[2]);
      for (int i = 0; i < 3; i++) begin
        s1_d_r[i]   <= s1_d_nxt[i];
        s2_d_r[i]   <= s1_d_r[i];
        s2_pr_r[i]  <= s1_d_r[i] * ax[i];
        s3_d_r[i]   <= s2_d_r[i];
        s4_d_r[i]   <= s3_d_r[i];
        s4_pa_r[i]  <= s3_t16_r * ax[i];
        s5_mag_r[i] <= s5_mag_nxt[i];
        s8_sq_r[i]  <= 62'(s7_side_r.c[i]) * 62'(s7_side_r.c[i]);
      end
    end
  end

  logic        sq_vld;
  logic [31:0] sq_root;
  awcd_side_t  sq_side;

  awcd_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .vld_in   (s9_vld_r),
    .rad_in   (s9_sum_r),
    .side_in  (s9_side_r),
    .vld_out  (sq_vld),
    .root_out (sq_root),
    .side_out (sq_side)
  );

  // gap stage
  logic       g_vld_r;
  awcd_side_t g_side_r, g_side_nxt;
  logic [31:0] g_root_r;
  logic [40:0] g_lw;
  logic [40:0] g_dist;
  logic [4:0]  g_kk;
  always_comb begin
    g_side_nxt = sq_side;
    g_lw = 41'(sq_root);
    g_kk = 5'(-sq_side.sh);
    if (sq_side.sh > 7'sd0) begin
      g_dist = g_lw << sq_side.sh[3:0];
    end else if (sq_side.sh < 7'sd0) begin
      g_dist = (g_lw + (41'd1 << (g_kk - 5'd1))) >> g_kk;
    end else begin
      g_dist = g_lw;
    end
    g_side_nxt.gap  = $signed(GAP_W'(wall_r)) - $signed(GAP_W'(g_dist));
    g_side_nxt.miss = sq_side.zero || (g_side_nxt.gap >= $signed(GAP_W'(sq_side.reach)));
  end

  logic             dv_vld;
  logic [2:0][18:0] dv_q;
  awcd_side_t       dv_side;

  awcd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .vld_in   (g_vld_r),
    .root_in  (g_root_r),
    .side_in  (g_side_r),
    .vld_out  (dv_vld),
    .q_out    (dv_q),
    .side_out (dv_side)
  );

  // stage 11: signed normal, centreline products, half sum
  logic               t1_vld_r;
  awcd_side_t         t1_side_r;
  logic signed [19:0] t1_n_r [3];
  logic signed [19:0] t1_n_nxt [3];
  logic signed [39:0] t1_dp_r [3];
  logic signed [43:0] t1_h_r;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t1_n_nxt[i] = dv_side.neg[i] ? -$signed({1'b0, dv_q[i]}) : $signed({1'b0, dv_q[i]});
    end
  end

  // stage 12: arc test, scaled normal
  logic               t2_vld_r;
  awcd_side_t         t2_side_r;
  logic signed [19:0] t2_n_r [3];
  logic signed [63:0] t2_hn_r [3];
  logic               t2_arc_r;
  logic signed [63:0] t2_dot;
  logic signed [63:0] t2_thr;
  assign t2_dot = 64'(t1_dp_r[0]) + 64'(t1_dp_r[1]) + 64'(t1_dp_r[2]);
  assign t2_thr = 64'(chs_r) <<< 18;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_vld_r  <= 1'b0;
      t1_vld_r <= 1'b0;
      t2_vld_r <= 1'b0;
    end else if (en) begin
      g_vld_r  <= sq_vld;
      t1_vld_r <= dv_vld;
      t2_vld_r <= t1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_side_r  <= g_side_nxt;
      g_root_r  <= sq_root;
      t1_side_r <= dv_side;
      t1_h_r    <= $signed(44'(dv_side.prad)) + 44'(dv_side.gap);
      t2_side_r <= t1_side_r;
      t2_arc_r  <= full_r || (t2_dot > t2_thr);
      for (int i = 0; i < 3; i++) begin
        t1_n_r[i]  <= t1_n_nxt[i];
        t1_dp_r[i] <= t1_n_nxt[i] * cd[i];
        t2_n_r[i]  <= t1_n_r[i];
        t2_hn_r[i] <= t1_h_r * t1_n_r[i];
      end
    end
  end

  // output register
  logic [223:0] out_tdata_r, out_tdata_nxt;
  logic         out_tuser_r, out_tuser_nxt;
  logic signed [31:0] o_gap;
  logic signed [31:0] o_ovl;
  logic signed [31:0] o_cp [3];
  logic signed [19:0] o_nrm [3];
  logic signed [63:0] o_pv [3];
  always_comb begin
    o_pv[0] = 64'(t2_side_r.px);
    o_pv[1] = 64'(t2_side_r.py);
    o_pv[2] = 64'(t2_side_r.pz);
    o_gap = sat32(64'(t2_side_r.gap));
    o_ovl = sat32($signed(64'(t2_side_r.prad)) - 64'(t2_side_r.gap));
    for (int i = 0; i < 3; i++) begin
      o_nrm[i] = -t2_n_r[i];
      o_cp[i]  = sat32(o_pv[i] + rnd_half(t2_hn_r[i], 19));
    end
    out_tuser_nxt = !t2_side_r.miss && t2_arc_r;
    out_tdata_nxt = '0;
    if (out_tuser_nxt) begin
      out_tdata_nxt[31:0]    = o_gap;
      out_tdata_nxt[51:32]   = o_nrm[0];
      out_tdata_nxt[71:52]   = o_nrm[1];
      out_tdata_nxt[91:72]   = o_nrm[2];
      out_tdata_nxt[123:92]  = o_ovl;
      out_tdata_nxt[155:124] = o_cp[0];
      out_tdata_nxt[187:156] = o_cp[1];
      out_tdata_nxt[219:188] = o_cp[2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      out_tvalid_r <= t2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tdata_r <= out_tdata_nxt;
      out_tuser_r <= out_tuser_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

// ===== rtl/awcd_checker.sv =====
// ----------------------------------------------------------------------------
// Arc wall contact detect checker
// Port-level properties of the result stream and of in_tready, bound to the top level.
// ----------------------------------------------------------------------------
module awcd_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [223:0] out_tdata,
  input logic         out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result transaction changed while stalled");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("non-contact result carries data");

  a_normal_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      ($signed(out_tdata[51:32]) <= 20'sd262144) &&
      ($signed(out_tdata[51:32]) >= -20'sd262144))
    else $error("normal x beyond unit range");

  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

endmodule

bind arc_wall_contact_detect awcd_checker u_awcd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ===== test/arc_wall_contact_detect_tb.sv =====
// ----------------------------------------------------------------------------
// Arc wall contact detect testbench
// Drives particles through the stream input, predicts each result with an
// independent fixed-point model of the cylinder arc contact test, and checks
// every result field in order. Covers register settings, directed corner
// cases, random streams with gaps and back-pressure, and a long output stall.
// ----------------------------------------------------------------------------
module arc_wall_contact_detect_tb;
  import awcd_pkg::*;

  typedef struct {
    logic signed [31:0] px, py, pz;
    logic [30:0]        prad, reach;
  } particle_t;

  typedef struct {
    logic               hit;
    logic signed [31:0] gap;
    logic signed [19:0] nx, ny, nz;
    logic signed [31:0] ovl;
    logic signed [31:0] cx, cy, cz;
  } contact_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [159:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [223:0] out_tdata;
  logic out_tuser;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [5:0] cfg_paddr = '0;
  logic [63:0] cfg_pwdata = '0;
  logic [63:0] cfg_prdata;
  logic cfg_pready;

  // wall registers as the predictor sees them
  logic [59:0]        w_axis = 60'h400000000000000;
  logic signed [31:0] w_px = 0, w_py = 32'sd65536, w_pz = 0;
  logic [30:0]        w_rad = 31'd65536;
  logic [59:0]        w_ctr = 60'h0000C000000000 << 0;
  logic signed [19:0] w_cos = 20'sd246333;
  logic               w_full = 1'b0;

  contact_t expected_q[$];
  int  fail_cnt = 0;
  int  hold_off = 0;
  int  rx_wait = 0;
  bit  rx_random = 1'b1;

  arc_wall_contact_detect u_top (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic signed [63:0] round_shift(logic signed [63:0] v, int sh);
    logic [63:0] m;
    m = v < 0 ? 64'(-v) : 64'(v);
    m = (m + (64'd1 << (sh - 1))) >> sh;
    return v < 0 ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [31:0] clamp32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else res >>= 1;
      b >>= 2;
    end
    return res;
  endfunction

  function automatic contact_t wall_contact(particle_t p);
    contact_t o;
    logic signed [63:0] pp[3], d[3], r[3], a[3], n[3], cd[3];
    logic [63:0] mag[3], c[3], m, sum, len, span, q;
    logic signed [63:0] t, t16, gap, dot, h;
    int s, k;
    o = '{default: '0};
    pp[0] = p.px; pp[1] = p.py; pp[2] = p.pz;
    d[0] = pp[0] - w_px; d[1] = pp[1] - w_py; d[2] = pp[2] - w_pz;
    t = 0; m = 0; sum = 0; s = 0; k = 0; dot = 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = $signed(w_axis[20*i +: 20]);
      cd[i] = $signed(w_ctr[20*i +: 20]);
      t += d[i] * a[i];
    end
    t16 = round_shift(t, 18);
    for (int i = 0; i < 3; i++) begin
      r[i] = d[i] - round_shift(t16 * a[i], 18);
      mag[i] = r[i] < 0 ? 64'(-r[i]) : 64'(r[i]);
      if (mag[i] > m) m = mag[i];
    end
    if (m == 0) return o;
    if (m >= (64'd1 << 31)) begin
      while ((m >> s) >= (64'd1 << 31)) s++;
    end else begin
      while ((m << k) < (64'd1 << 30)) k++;
    end
    for (int i = 0; i < 3; i++) begin
      c[i] = s != 0 ? (mag[i] >> s) : (mag[i] << k);
      sum += c[i] * c[i];
    end
    len = floor_sqrt(sum);
    span = s != 0 ? (len << s) : (k != 0 ? ((len + (64'd1 << (k - 1))) >> k) : len);
    gap = $signed({33'd0, w_rad}) - $signed(span);
    if (gap >= $signed({33'd0, p.reach})) return o;
    for (int i = 0; i < 3; i++) begin
      q = ((c[i] << 19) + len) / (len << 1);
      n[i] = r[i] < 0 ? -$signed(q) : $signed(q);
    end
    if (!w_full) begin
      for (int i = 0; i < 3; i++) dot += n[i] * cd[i];
      if (!(dot > 64'(w_cos) * 64'sd262144)) return o;
    end
    h = $signed({33'd0, p.prad}) + gap;
    o.hit = 1'b1;
    o.gap = clamp32(gap);
    o.nx = 20'(-n[0]); o.ny = 20'(-n[1]); o.nz = 20'(-n[2]);
    o.ovl = clamp32($signed({33'd0, p.prad}) - gap);
    o.cx = clamp32(pp[0] + round_shift(h * n[0], 19));
    o.cy = clamp32(pp[1] + round_shift(h * n[1], 19));
    o.cz = clamp32(pp[2] + round_shift(h * n[2], 19));
    return o;
  endfunction

  task automatic wait_cycles(int n);
    repeat (n) @(posedge clk);
  endtask

  task automatic send_particle(particle_t p);
    int idle_n;
    idle_n = $urandom_range(0, 6);
    if (idle_n != 0) begin
      in_tvalid <= 1'b0;
      wait_cycles(idle_n);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {p.reach, p.prad, p.pz, p.py, p.px};
    do @(posedge clk); while (!in_tready);
    expected_q.push_back(wall_contact(p));
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 3'b000}; cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    case (idx)
      REG_AXIS_VECTOR:  w_axis = val[59:0];
      REG_AXIS_POINT_X: w_px = val[31:0];
      REG_AXIS_POINT_Y: w_py = val[31:0];
      REG_AXIS_POINT_Z: w_pz = val[31:0];
      REG_WALL_RADIUS:  w_rad = val[30:0];
      REG_CENTRE_DIR:   w_ctr = val[59:0];
      REG_COS_HALF:     w_cos = val[19:0];
      default:          w_full = val[0];
    endcase
    @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    wait_cycles(80);
  endtask

  function automatic logic [59:0] pack_vec(int x, int y, int z);
    return {20'(z), 20'(y), 20'(x)};
  endfunction

  function automatic particle_t near_wall();
    particle_t p;
    int ang;
    // box around the axis point in x and y, out to about twice the wall radius
    ang = $urandom_range(0, 7);
    p.px = w_px + (ang[0] ? 1 : -1) * $signed(32'($urandom_range(0, 2 * w_rad + 100)));
    p.py = w_py + (ang[1] ? 1 : -1) * $signed(32'($urandom_range(0, 2 * w_rad + 100)));
    p.pz = w_pz + $signed(32'($urandom_range(0, 1 << 20))) - (1 << 19);
    p.prad = $urandom_range(0, 1 << 17);
    p.reach = p.prad + $urandom_range(0, 1 << 16);
    return p;
  endfunction

  function automatic particle_t any_particle();
    particle_t p;
    p.px = $urandom; p.py = $urandom; p.pz = $urandom;
    p.prad = $urandom; p.reach = $urandom;
    return p;
  endfunction

  always @(posedge clk) begin
    contact_t e;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result transaction");
          fail_cnt++;
        end else begin
          e = expected_q.pop_front();
          if (out_tuser !== e.hit) begin
            $error("contact exp %0d got %0d", e.hit, out_tuser); fail_cnt++;
          end
          if ($signed(out_tdata[31:0]) !== e.gap) begin
            $error("gap exp %0d got %0d", e.gap, $signed(out_tdata[31:0])); fail_cnt++;
          end
          if ($signed(out_tdata[51:32]) !== e.nx) begin
            $error("normal_x exp %0d got %0d", e.nx, $signed(out_tdata[51:32])); fail_cnt++;
          end
          if ($signed(out_tdata[71:52]) !== e.ny) begin
            $error("normal_y exp %0d got %0d", e.ny, $signed(out_tdata[71:52])); fail_cnt++;
          end
          if ($signed(out_tdata[91:72]) !== e.nz) begin
            $error("normal_z exp %0d got %0d", e.nz, $signed(out_tdata[91:72])); fail_cnt++;
          end
          if ($signed(out_tdata[123:92]) !== e.ovl) begin
            $error("overlap exp %0d got %0d", e.ovl, $signed(out_tdata[123:92]));
            fail_cnt++;
          end
          if ($signed(out_tdata[155:124]) !== e.cx) begin
            $error("contact_x exp %0d got %0d", e.cx, $signed(out_tdata[155:124]));
            fail_cnt++;
          end
          if ($signed(out_tdata[187:156]) !== e.cy) begin
            $error("contact_y exp %0d got %0d", e.cy, $signed(out_tdata[187:156]));
            fail_cnt++;
          end
          if ($signed(out_tdata[219:188]) !== e.cz) begin
            $error("contact_z exp %0d got %0d", e.cz, $signed(out_tdata[219:188]));
            fail_cnt++;
          end
        end
      end
    end
  end

  // receiver: per-transaction idle draw, always ready when not random, or a counted long hold-off
  always @(posedge clk) begin
    int n;
    n = $urandom_range(0, 6);
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_tready <= 1'b0;
    end else if (!rx_random) begin
      out_tready <= 1'b1;
    end else if (rx_wait > 0) begin
      rx_wait <= rx_wait - 1;
      out_tready <= 1'b0;
    end else if (out_tvalid && out_tready) begin
      if (n == 0) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b0;
        rx_wait <= n - 1;
      end
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic test_directed();
    particle_t p;
    // on axis, exactly on wall, below centreline, above, extremes
    p = '{0, 65536, 0, 1000, 1000};            send_particle(p);
    p = '{0, 0, 0, 0, 0};                      send_particle(p);
    p = '{0, 0, 0, 31'h7fffffff, 31'h7fffffff}; send_particle(p);
    p = '{0, -65536, 5, 100, 200};             send_particle(p);
    p = '{0, 2 * 65536, 0, 100, 200};          send_particle(p);
    p = '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 31'h7fffffff, 31'h7fffffff};
    send_particle(p);
    p = '{32'sh80000000, 32'sh7fffffff, 32'sh80000000, 0, 31'h7fffffff};
    send_particle(p);
    p = '{32'sh80000000, 32'sh80000000, 0, 31'h7fffffff, 31'h7fffffff};
    send_particle(p);
    p = '{20000, -30000, 0, 40000, 70000};     send_particle(p);
    p = '{-1, 65535, 0, 3, 5};                 send_particle(p);
    p = '{0, 65536 + 1, 0, 3, 31'h7fffffff};   send_particle(p);
    drain();
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) send_particle(($urandom_range(0, 4) != 0) ?
                                              near_wall() : any_particle());
    drain();
  endtask

  task automatic test_registers();
    // full circle with tilted axis and offset point
    write_reg(REG_FULL_CIRCLE, 64'd1);
    write_reg(REG_AXIS_VECTOR, pack_vec(0, 185364, 185364));
    write_reg(REG_AXIS_POINT_X, 64'(32'sh80000000));
    write_reg(REG_AXIS_POINT_Z, 64'(32'sh7fffffff));
    write_reg(REG_WALL_RADIUS, 64'h7fffffff);
    test_random(60);
    write_reg(REG_AXIS_POINT_X, 64'(-32'sd200000));
    write_reg(REG_AXIS_POINT_Y, 64'(32'sd300000));
    write_reg(REG_AXIS_POINT_Z, 64'd0);
    write_reg(REG_AXIS_VECTOR, pack_vec(0, 0, -262144));
    write_reg(REG_WALL_RADIUS, 64'd0);
    test_random(50);
    // narrow and widest arcs, odd centrelines, non-unit vectors
    write_reg(REG_FULL_CIRCLE, 64'd0);
    write_reg(REG_WALL_RADIUS, 64'd200000);
    write_reg(REG_CENTRE_DIR, pack_vec(262144, 0, 0));
    write_reg(REG_COS_HALF, 64'(20'sh80000));
    test_random(60);
    write_reg(REG_COS_HALF, 64'd262144);
    write_reg(REG_CENTRE_DIR, 60'hfffffffffffffff);
    test_random(40);
    write_reg(REG_COS_HALF, 64'(-20'sd262144));
    write_reg(REG_AXIS_VECTOR, 60'h7ffff7ffff7ffff);
    write_reg(REG_CENTRE_DIR, pack_vec(-185364, 185364, 0));
    test_random(40);
    write_reg(REG_COS_HALF, 64'd0);
    write_reg(REG_AXIS_VECTOR, 60'h800008000080000);
    write_reg(REG_CENTRE_DIR, 60'h555555555555555);
    test_random(40);
  endtask

  task automatic test_stall();
    write_reg(REG_AXIS_VECTOR, pack_vec(0, 0, 262144));
    write_reg(REG_CENTRE_DIR, pack_vec(0, 262144, 0));
    write_reg(REG_COS_HALF, 64'd0);
    write_reg(REG_WALL_RADIUS, 64'd131072);
    hold_off <= 300;
    for (int i = 0; i < 120; i++) send_particle(near_wall());
    drain();
    rx_random = 1'b0;
    for (int i = 0; i < 60; i++) send_particle(near_wall());
    rx_random = 1'b1;
    drain();
  endtask

  initial begin
    wait_cycles(10);
    rst_n <= 1'b1;
    wait_cycles(2);
    test_directed();
    test_random(100);
    test_registers();
    test_stall();
    if (fail_cnt == 0) begin
      $display("PASS arc_wall_contact_detect");
    end else begin
      $display("FAIL arc_wall_contact_detect");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL arc_wall_contact_detect");
    $finish;
  end

endmodule
